>>> src/vrfr_pkg.sv
`default_nettype none
package vrfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 65536;
  localparam int unsigned TICKS_PER_UNIT_DEF  = 3000;
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_COMMIT = 2'd1;
  localparam logic [1:0] ACT_DROP   = 2'd2;

  localparam logic CFG_RECORD_ENABLE = 1'b0;
  localparam logic CFG_OFFSET_UNITS  = 1'b1;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
  } in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  byte_value;
    logic [15:0] byte_offset;
    logic [16:0] frame_length;
    logic [24:0] frame_time;
    logic        last_result;
  } out_t;

  // one queue entry: an optional byte write and an optional frame end
  typedef struct packed {
    logic        has_wr;
    logic [7:0]  wr_byte;
    logic [15:0] wr_offset;
    logic        has_end;
    logic [1:0]  end_action;
    logic [16:0] length;
    logic [31:0] diff;
  } entry_t;

endpackage
`default_nettype wire

>>> src/vrfr_front.sv
`default_nettype none
module vrfr_front import vrfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   accept,
  input  wire in_t    in_data,
  input  wire logic   record_enable,
  output entry_t      entry,
  output logic        push
);

  localparam int unsigned FW = $clog2(MAX_FRAME_BYTES + 1);

  typedef enum logic [12:0] {
    PH_RTP      = 13'b0000000000001,
    PH_RTPX     = 13'b0000000000010,
    PH_EXTHDR   = 13'b0000000000100,
    PH_HDRTAIL  = 13'b0000000001000,
    PH_DESC     = 13'b0000000010000,
    PH_XEXT     = 13'b0000000100000,
    PH_PICID1   = 13'b0000001000000,
    PH_PICID2   = 13'b0000010000000,
    PH_TL0      = 13'b0000100000000,
    PH_TK       = 13'b0001000000000,
    PH_PAYFIRST = 13'b0010000000000,
    PH_PAYLOAD  = 13'b0100000000000,
    PH_SKIP     = 13'b1000000000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [10:0] count, count_next;
  logic [10:0] hdr_end, hdr_end_next;
  logic        marker, marker_next;
  logic [31:0] ptime, ptime_next;
  logic [7:0]  dflags, dflags_next;
  logic        keep, keep_next;
  logic        assembling, assembling_next;
  logic [FW-1:0] fill, fill_next;
  logic        ovf, ovf_next;
  logic        kf_seen, kf_seen_next;
  logic        base_valid, base_valid_next;
  logic [31:0] base_time, base_time_next;
  entry_t      ent;

  function automatic phase_t next_option(input logic [7:0] f);
    if (f[7]) return PH_PICID1;
    if (f[6]) return PH_TL0;
    if (f[5] || f[4]) return PH_TK;
    return PH_PAYFIRST;
  endfunction

  logic [7:0]  b;
  logic [10:0] rel;
  logic [15:0] words;
  logic [18:0] ext_end;

  assign b       = in_data.packet_byte;
  assign rel     = count - hdr_end;
  assign words   = {dflags, b};
  assign ext_end = 19'(hdr_end) + 19'd4 + {1'b0, words, 2'b00};

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    hdr_end_next    = hdr_end;
    marker_next     = marker;
    ptime_next      = ptime;
    dflags_next     = dflags;
    keep_next       = keep;
    assembling_next = assembling;
    fill_next       = fill;
    ovf_next        = ovf;
    kf_seen_next    = kf_seen;
    base_valid_next = base_valid;
    base_time_next  = base_time;
    ent             = '0;

    if (count == 11'd12 && !base_valid) begin
      base_time_next  = ptime;
      base_valid_next = 1'b1;
    end

    case (phase)
      PH_RTP, PH_RTPX: begin
        if (count == 11'd0) begin
          hdr_end_next = 11'd12 + {5'd0, b[3:0], 2'b00};
          phase_next   = b[4] ? PH_RTPX : PH_RTP;
        end else if (count == 11'd1) begin
          marker_next = b[7];
        end else if (count >= 11'd4 && count <= 11'd7) begin
          ptime_next = {ptime[23:0], b};
        end
        if (count + 11'd1 >= 11'd12 && count + 11'd1 == hdr_end_next)
          phase_next = (phase_next == PH_RTPX) ? PH_EXTHDR : PH_DESC;
      end
      PH_EXTHDR: begin
        if (rel == 11'd2) begin
          dflags_next = b;
        end else if (rel == 11'd3) begin
          dflags_next = '0;
          if (ext_end > 19'd2047) begin
            phase_next = PH_SKIP;
          end else begin
            hdr_end_next = ext_end[10:0];
            phase_next   = (words != 16'd0) ? PH_HDRTAIL : PH_DESC;
          end
        end
      end
      PH_HDRTAIL: begin
        if (count + 11'd1 == hdr_end) phase_next = PH_DESC;
      end
      PH_DESC: begin
        dflags_next = {6'd0, b[4] && (b[2:0] == 3'd0), b[4]};
        phase_next  = b[7] ? PH_XEXT : PH_PAYFIRST;
      end
      PH_XEXT: begin
        dflags_next = dflags | (b & 8'hF0);
        phase_next  = next_option(dflags_next);
      end
      PH_PICID1: begin
        dflags_next = dflags & 8'h7F;
        phase_next  = b[7] ? PH_PICID2 : next_option(dflags_next);
      end
      PH_PICID2: phase_next = next_option(dflags);
      PH_TL0: begin
        dflags_next = dflags & 8'hBF;
        phase_next  = next_option(dflags_next);
      end
      PH_TK: begin
        dflags_next = dflags & 8'hCF;
        phase_next  = next_option(dflags_next);
      end
      PH_PAYFIRST, PH_PAYLOAD: begin
        if (phase == PH_PAYFIRST) begin
          if (!kf_seen && dflags[1] && !b[0]) kf_seen_next = 1'b1;
          // decide whether this packet belongs to a frame
          keep_next = kf_seen_next;
          if (keep_next) begin
            if (dflags[0]) begin
              fill_next = '0;
              ovf_next  = 1'b0;
            end else if (!assembling) begin
              keep_next = 1'b0;
            end
          end
          phase_next = PH_PAYLOAD;
        end
        if (keep_next && !ovf_next) begin
          if (32'(fill_next) < MAX_FRAME_BYTES) begin
            ent.has_wr    = 1'b1;
            ent.wr_byte   = b;
            ent.wr_offset = 16'(fill_next);
            fill_next     = fill_next + FW'(1);
          end else begin
            ovf_next = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (count != 11'd2047) count_next = count + 11'd1;

    if (in_data.packet_end) begin
      if (phase_next == PH_PAYFIRST) begin
        keep_next = kf_seen_next;
        if (keep_next) begin
          if (dflags_next[0]) begin
            fill_next = '0;
            ovf_next  = 1'b0;
          end else if (!assembling) begin
            keep_next = 1'b0;
          end
        end
        phase_next = PH_PAYLOAD;
      end
      if (phase_next == PH_PAYLOAD && keep_next) begin
        if (ovf_next) begin
          ent.has_end     = 1'b1;
          ent.end_action  = ACT_DROP;
          fill_next       = '0;
          ovf_next        = 1'b0;
          assembling_next = 1'b0;
        end else if (marker_next) begin
          ent.has_end     = 1'b1;
          ent.end_action  = ACT_COMMIT;
          ent.length      = 17'(fill_next);
          ent.diff        = ptime_next - base_time_next;
          fill_next       = '0;
          assembling_next = 1'b0;
        end else begin
          assembling_next = 1'b1;
        end
      end
      phase_next   = PH_RTP;
      count_next   = '0;
      hdr_end_next = '0;
      marker_next  = 1'b0;
      ptime_next   = '0;
      dflags_next  = '0;
      keep_next    = 1'b0;
    end
  end

  assign entry = ent;
  assign push  = accept && record_enable && (ent.has_wr || ent.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RTP;
      count      <= '0;
      hdr_end    <= '0;
      marker     <= 1'b0;
      ptime      <= '0;
      dflags     <= '0;
      keep       <= 1'b0;
      assembling <= 1'b0;
      fill       <= '0;
      ovf        <= 1'b0;
      kf_seen    <= 1'b0;
      base_valid <= 1'b0;
      base_time  <= '0;
    end else if (accept && record_enable) begin
      phase      <= phase_next;
      count      <= count_next;
      hdr_end    <= hdr_end_next;
      marker     <= marker_next;
      ptime      <= ptime_next;
      dflags     <= dflags_next;
      keep       <= keep_next;
      assembling <= assembling_next;
      fill       <= fill_next;
      ovf        <= ovf_next;
      kf_seen    <= kf_seen_next;
      base_valid <= base_valid_next;
      base_time  <= base_time_next;
    end
  end

endmodule
`default_nettype wire

>>> src/vrfr_queue.sv
`default_nettype none
module vrfr_queue import vrfr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  output logic        not_empty,
  input  wire logic   pop,
  output entry_t      head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full      = (32'(count) == DEPTH);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CW'(1))
    else $error("queue count did not advance");

endmodule
`default_nettype wire

>>> src/vrfr_back.sv
`default_nettype none
module vrfr_back import vrfr_pkg::*; #(
  parameter int unsigned TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire entry_t      q_head,
  output logic             q_pop,
  input  wire logic [23:0] offset_units,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data
);

  // exact reciprocal for 32-bit dividends: floor(x * MAGIC / 2^(32 + LSH))
  localparam int unsigned LSH = $clog2(TICKS_PER_UNIT);
  localparam logic [63:0] MAGIC_W = ((64'd1 << (32 + LSH)) + 64'(TICKS_PER_UNIT) - 64'd1) /
                                    64'(TICKS_PER_UNIT);
  localparam logic [32:0] MAGIC = MAGIC_W[32:0];

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WR   = 4'b0010,
    S_DIV  = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t        state, state_next;
  entry_t        cur;
  logic [31:0]   quot;
  logic [31:0]   dvd;
  logic [48:0]   p_lo;
  logic [47:0]   p_hi;
  logic [64:0]   prod;
  logic          step;
  logic          done;

  assign prod = {p_hi, 17'd0} + {16'd0, p_lo};

  assign out_valid = (state == S_WR) || (state == S_END);
  assign done      = out_valid && !out_stall &&
                     ((state == S_END) || !cur.has_end);
  assign q_pop     = q_valid && ((state == S_IDLE) || done);

  always_comb begin
    out_data = '0;
    if (state == S_WR) begin
      out_data.action      = ACT_WRITE;
      out_data.byte_value  = cur.wr_byte;
      out_data.byte_offset = cur.wr_offset;
      out_data.last_result = !cur.has_end;
    end else begin
      out_data.action      = cur.end_action;
      out_data.last_result = 1'b1;
      if (cur.end_action == ACT_COMMIT) begin
        out_data.frame_length = cur.length;
        out_data.frame_time   = quot[24:0] + {1'b0, offset_units};
      end
    end
  end

  // where a fresh entry goes first
  function automatic state_t first_state(input entry_t e);
    if (e.has_wr) return S_WR;
    if (e.end_action == ACT_COMMIT) return S_DIV;
    return S_END;
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = first_state(q_head);
      S_WR: begin
        if (!out_stall) begin
          if (cur.has_end) state_next = (cur.end_action == ACT_COMMIT) ? S_DIV : S_END;
          else             state_next = q_valid ? first_state(q_head) : S_IDLE;
        end
      end
      S_DIV:   if (step) state_next = S_END;
      S_END:   if (!out_stall) state_next = q_valid ? first_state(q_head) : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (state_next == S_DIV && state != S_DIV) begin
      dvd  <= (q_pop ? q_head.diff : cur.diff);
      step <= 1'b0;
    end else if (state == S_DIV) begin
      // partial products first, then sum and shift
      if (!step) begin
        p_lo <= 49'(dvd) * 49'(MAGIC[16:0]);
        p_hi <= 48'(dvd) * 48'(MAGIC[32:17]);
      end else begin
        quot <= 32'(prod >> (32 + LSH));
      end
      step <= 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> src/vp8_rtp_frame_reassembler_top.sv
// path: an accepted byte reaches its earliest result transaction via the queue, then the back-end load
// throughput: one packet byte per cycle while the queue has room; a commit also passes through
//   the back-end division state for reciprocal-multiply timestamp scaling, buffered by the 4-entry queue
// a byte that gives both a write and a commit or drop yields two result transactions, the write first
// reset: synchronous active-high rst clears the parser, frame state, queue pointers, back-end state and config
`default_nettype none
module vp8_rtp_frame_reassembler_top import vrfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int unsigned TICKS_PER_UNIT  = TICKS_PER_UNIT_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);

  // configuration registers; the user must write them only while idle, the block does not enforce it
  logic        record_enable;
  logic [23:0] offset_units;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_enable <= 1'b0;
      offset_units  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RECORD_ENABLE: record_enable <= cfg_data[0];
        CFG_OFFSET_UNITS:  offset_units  <= cfg_data;
        default: ;
      endcase
    end
  end

  entry_t push_data, head;
  logic   push, full, not_empty, pop, accept;

  // a byte is taken whenever the queue has room for its entry
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // front: header and descriptor parsing, frame tracking
  vrfr_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .in_data(in_data),
    .record_enable(record_enable), .entry(push_data), .push(push)
  );

  // queue between parser and result sequencer
  vrfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .not_empty(not_empty), .pop(pop), .head(head)
  );

  // back: emits writes, scales timestamps, emits commit or drop
  vrfr_back #(.TICKS_PER_UNIT(TICKS_PER_UNIT)) u_back (
    .clk(clk), .rst(rst), .q_valid(not_empty), .q_head(head), .q_pop(pop),
    .offset_units(offset_units), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

>>> sim/tb_vp8_rtp_frame_reassembler_top.sv
`default_nettype none
module tb_vp8_rtp_frame_reassembler_top;
  import vrfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_CAP = 65536;
  localparam int TICKS     = 3000;
  localparam int SETTLE    = 80;   // a commit passes through the back-end division state, queue is 4 deep

  typedef enum logic [3:0] {
    P_RTP, P_RTPX, P_EXTHDR, P_HDRTAIL, P_DESC, P_XEXT, P_PICID1, P_PICID2,
    P_TL0, P_TK, P_PAYFIRST, P_PAYLOAD, P_SKIP
  } phase_e;

  typedef enum logic [1:0] {CHK_NONE, CHK_QUIET, CHK_ACT} chk_e;

  typedef struct {
    logic [7:0] pbyte;
    logic       pend;
    chk_e       chk;
    logic [1:0] act;
  } row_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_index;
  logic [23:0] cfg_data;

  vp8_rtp_frame_reassembler_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #40ms;
    $display("vp8_rtp_frame_reassembler_top regression: fail");
    $finish;
  end

  // predictor copy of the block state
  logic        rec_en;
  logic [23:0] start_ofs;
  phase_e      phase;
  logic [10:0] pkt_idx;
  logic [10:0] hdr_end;
  logic        marker;
  logic [31:0] pkt_ts;
  logic [7:0]  dflags;
  logic        keep;
  logic        in_frame;
  logic [16:0] fill;
  logic        ovf;
  logic        key_seen;
  logic        base_ok;
  logic [31:0] base_ts;

  out_t frame_events[$];   // expected results, oldest first
  int   errors;
  int   items_sent;
  int   n_writes, n_commits, n_drops;
  bit   calm;              // no idling on either side while set
  logic [31:0] ts_run;

  task automatic note_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic phase_e after_option(input logic [7:0] f);
    if (f[7]) return P_PICID1;
    if (f[6]) return P_TL0;
    if (f[5] || f[4]) return P_TK;
    return P_PAYFIRST;
  endfunction

  task automatic choose_keep();
    keep = key_seen;
    if (keep) begin
      if (dflags[0]) begin
        fill = '0;
        ovf  = 1'b0;
      end else if (!in_frame) begin
        keep = 1'b0;
      end
    end
  endtask

  task automatic clear_pkt();
    phase   = P_RTP;
    pkt_idx = '0;
    hdr_end = '0;
    marker  = 1'b0;
    pkt_ts  = '0;
    dflags  = '0;
    keep    = 1'b0;
  endtask

  // one packet byte through the predictor; expected results go to frame_events
  task automatic reassemble(input logic [7:0] b, input logic fin, output int n,
                            output logic [1:0] last_act);
    out_t r;
    int idx;
    int rel;
    int words;
    int stop;
    logic [31:0] diff;
    n = 0;
    last_act = ACT_WRITE;
    if (!rec_en) return;
    idx = pkt_idx;
    if (idx == 12 && !base_ok) begin
      base_ts = pkt_ts;
      base_ok = 1'b1;
    end
    case (phase)
      P_RTP, P_RTPX: begin
        if (idx == 0) begin
          hdr_end = 11'(12 + 4 * b[3:0]);
          phase   = b[4] ? P_RTPX : P_RTP;
        end else if (idx == 1) begin
          marker = b[7];
        end else if (idx >= 4 && idx <= 7) begin
          pkt_ts = {pkt_ts[23:0], b};
        end
        if (idx + 1 >= 12 && idx + 1 == int'(hdr_end))
          phase = (phase == P_RTPX) ? P_EXTHDR : P_DESC;
      end
      P_EXTHDR: begin
        rel = idx - int'(hdr_end);
        if (rel == 2) begin
          dflags = b;
        end else if (rel == 3) begin
          words  = {dflags, b};
          stop   = int'(hdr_end) + 4 + 4 * words;
          dflags = '0;
          if (stop > 2047) begin
            phase = P_SKIP;
          end else begin
            hdr_end = 11'(stop);
            phase   = (words != 0) ? P_HDRTAIL : P_DESC;
          end
        end
      end
      P_HDRTAIL: if (idx + 1 == int'(hdr_end)) phase = P_DESC;
      P_DESC: begin
        dflags = {6'd0, b[4] && b[2:0] == 3'd0, b[4]};
        phase  = b[7] ? P_XEXT : P_PAYFIRST;
      end
      P_XEXT: begin
        dflags = dflags | (b & 8'hF0);
        phase  = after_option(dflags);
      end
      P_PICID1: begin
        dflags[7] = 1'b0;
        phase = b[7] ? P_PICID2 : after_option(dflags);
      end
      P_PICID2: phase = after_option(dflags);
      P_TL0: begin
        dflags[6] = 1'b0;
        phase = after_option(dflags);
      end
      P_TK: begin
        dflags[5:4] = 2'b00;
        phase = after_option(dflags);
      end
      P_PAYFIRST, P_PAYLOAD: begin
        if (phase == P_PAYFIRST) begin
          if (!key_seen && dflags[1] && !b[0]) key_seen = 1'b1;
          choose_keep();
          phase = P_PAYLOAD;
        end
        if (keep && !ovf) begin
          if (fill < FRAME_CAP) begin
            r = '0;
            r.action      = ACT_WRITE;
            r.byte_value  = b;
            r.byte_offset = fill[15:0];
            frame_events.push_back(r);
            n++;
            fill++;
          end else begin
            ovf = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (pkt_idx < 11'd2047) pkt_idx++;
    if (fin) begin
      if (phase == P_PAYFIRST) begin
        choose_keep();
        phase = P_PAYLOAD;
      end
      if (phase == P_PAYLOAD && keep) begin
        if (ovf) begin
          r = '0;
          r.action = ACT_DROP;
          frame_events.push_back(r);
          n++;
          fill = '0;
          ovf = 1'b0;
          in_frame = 1'b0;
        end else if (marker) begin
          diff = pkt_ts - base_ts;
          r = '0;
          r.action       = ACT_COMMIT;
          r.frame_length = fill;
          r.frame_time   = 25'(diff / TICKS + start_ofs);
          frame_events.push_back(r);
          n++;
          fill = '0;
          in_frame = 1'b0;
        end else begin
          in_frame = 1'b1;
        end
      end
      clear_pkt();
    end
    if (n > 0) begin
      frame_events[$].last_result = 1'b1;
      last_act = frame_events[$].action;
    end
  endtask

  // output side: random stall, checked at the rising edge
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin : out_check
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_events.size() == 0) begin
        note_mismatch("result transaction with nothing expected");
      end else begin
        want = frame_events.pop_front();
        if (out_data.action !== want.action)
          note_mismatch($sformatf("action %0d, want %0d", out_data.action, want.action));
        if (out_data.byte_value !== want.byte_value)
          note_mismatch($sformatf("byte_value %h, want %h",
                                  out_data.byte_value, want.byte_value));
        if (out_data.byte_offset !== want.byte_offset)
          note_mismatch($sformatf("byte_offset %0d, want %0d",
                                  out_data.byte_offset, want.byte_offset));
        if (out_data.frame_length !== want.frame_length)
          note_mismatch($sformatf("frame_length %0d, want %0d",
                                  out_data.frame_length, want.frame_length));
        if (out_data.frame_time !== want.frame_time)
          note_mismatch($sformatf("frame_time %0d, want %0d",
                                  out_data.frame_time, want.frame_time));
        if (out_data.last_result !== want.last_result)
          note_mismatch($sformatf("last_result %b, want %b",
                                  out_data.last_result, want.last_result));
        case (want.action)
          ACT_WRITE:  n_writes++;
          ACT_COMMIT: n_commits++;
          default:    n_drops++;
        endcase
      end
    end
  end

  // one byte transaction; valid stays up for a following byte
  task automatic push_byte(input logic [7:0] b, input logic fin, output int n,
                           output logic [1:0] last_act);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.packet_byte = b;
    in_data.packet_end  = fin;
    do @(posedge clk); while (in_stall);
    reassemble(b, fin, n, last_act);
    if (rec_en) items_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait for every expected result, then let the back end settle
  task automatic drain();
    go_quiet();
    wait (frame_events.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_RECORD_ENABLE) rec_en = val[0];
    else start_ofs = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // builds one rtp packet; s_sel/m_sel: 0 random, 1 force set, 2 force clear
  task automatic send_packet(input int pay_len, input int s_sel, input int m_sel,
                             input bit broken);
    logic [7:0] pk[$];
    logic [7:0] d, e, t;
    logic [3:0] cc;
    logic       xb, mk, sb, longx;
    int words, n, cut;
    logic [1:0] la;
    cc = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
    xb = ($urandom_range(3) == 0);
    longx = xb && ($urandom_range(15) == 0);
    mk = (m_sel == 0) ? 1'($urandom_range(1)) : (m_sel == 1);
    sb = (s_sel == 0) ? 1'($urandom_range(1)) : (s_sel == 1);
    pk.push_back({2'b10, 1'($urandom_range(1)), xb, cc});
    pk.push_back({mk, 7'($urandom_range(127))});
    pk.push_back(8'($urandom_range(255)));
    pk.push_back(8'($urandom_range(255)));
    // timestamp mostly advances a little, sometimes jumps anywhere
    if ($urandom_range(9) == 0) ts_run = $urandom();
    else ts_run += $urandom_range(9000);
    for (int i = 3; i >= 0; i--) pk.push_back(ts_run[8*i +: 8]);
    repeat (4 + 4 * cc) pk.push_back(8'($urandom_range(255)));
    if (xb) begin
      pk.push_back(8'($urandom_range(255)));
      pk.push_back(8'($urandom_range(255)));
      words = longx ? 16'h0200 | $urandom_range(16'hFDFF) : $urandom_range(2);
      pk.push_back(words[15:8]);
      pk.push_back(words[7:0]);
      if (longx) words = $urandom_range(3);
      repeat (4 * words) pk.push_back(8'($urandom_range(255)));
    end
    d = 8'($urandom_range(255));
    d[4] = sb;
    if (sb && $urandom_range(3) != 0) d[2:0] = 3'd0;
    pk.push_back(d);
    if (d[7]) begin
      e = 8'($urandom_range(255));
      pk.push_back(e);
      if (e[7]) begin
        t = 8'($urandom_range(255));
        pk.push_back(t);
        if (t[7]) pk.push_back(8'($urandom_range(255)));
      end
      if (e[6]) pk.push_back(8'($urandom_range(255)));
      if (e[5] || e[4]) pk.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < pay_len; i++) begin
      t = 8'($urandom_range(255));
      if (i == 0 && (s_sel == 1 || $urandom_range(9) < 7)) t[0] = 1'b0;
      pk.push_back(t);
    end
    if (broken) begin
      cut = $urandom_range(pk.size(), 1);
      while (pk.size() > cut) void'(pk.pop_back());
    end
    for (int i = 0; i < pk.size(); i++)
      push_byte(pk[i], i == pk.size() - 1, n, la);
  endtask

  task automatic send_noise();
    int len, n;
    logic [1:0] la;
    len = $urandom_range(20, 1);
    for (int i = 0; i < len; i++)
      push_byte(8'($urandom_range(255)), i == len - 1, n, la);
  endtask

  // directed rows: the first two go in while recording is off
  row_t plan[] = '{
    '{8'hFF, 1'b1, CHK_QUIET, ACT_WRITE},
    '{8'h00, 1'b0, CHK_QUIET, ACT_WRITE},
    // keyframe packet with marker: header, descriptor, two payload bytes
    '{8'h80, 1'b0, CHK_QUIET, ACT_WRITE},
    '{8'hE0, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'h00, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'h01, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'hFF, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'hFF, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'hFF, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'hFF, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'h12, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'h34, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'h56, 1'b0, CHK_NONE,  ACT_WRITE},
    '{8'h78, 1'b0, CHK_QUIET, ACT_WRITE},
    '{8'h10, 1'b0, CHK_QUIET, ACT_WRITE},
    '{8'h00, 1'b0, CHK_ACT,   ACT_WRITE},
    '{8'hFF, 1'b1, CHK_ACT,   ACT_COMMIT},
    // packet cut short inside the rtp header
    '{8'h80, 1'b0, CHK_QUIET, ACT_WRITE},
    '{8'h80, 1'b0, CHK_QUIET, ACT_WRITE},
    '{8'hAA, 1'b1, CHK_QUIET, ACT_WRITE}
  };

  initial begin : stimulus
    int n;
    logic [1:0] la;
    int goal;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RECORD_ENABLE;
    cfg_data  = '0;
    errors = 0;
    items_sent = 0;
    n_writes = 0;
    n_commits = 0;
    n_drops = 0;
    calm = 1'b0;
    ts_run = $urandom();
    rec_en = 1'b0;
    start_ofs = '0;
    clear_pkt();
    in_frame = 1'b0;
    fill = '0;
    ovf = 1'b0;
    key_seen = 1'b0;
    base_ok = 1'b0;
    base_ts = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    write_reg(CFG_RECORD_ENABLE, 24'd0);
    for (int i = 0; i < plan.size(); i++) begin
      if (i == 2) begin
        drain();
        write_reg(CFG_OFFSET_UNITS, 24'hFFFFFF);
        write_reg(CFG_RECORD_ENABLE, 24'd1);
      end
      push_byte(plan[i].pbyte, plan[i].pend, n, la);
      if (plan[i].chk == CHK_QUIET && n != 0)
        note_mismatch($sformatf("row %0d should give no result", i));
      if (plan[i].chk == CHK_ACT && (n == 0 || la != plan[i].act))
        note_mismatch($sformatf("row %0d action %0d, want %0d", i, la, plan[i].act));
    end
    drain();

    // random part, in phases with different start offsets
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_reg(CFG_OFFSET_UNITS, 24'd0);
        1: write_reg(CFG_OFFSET_UNITS, 24'($urandom()));
        2: write_reg(CFG_OFFSET_UNITS, 24'hFFFFFF);
        default: write_reg(CFG_OFFSET_UNITS, 24'($urandom_range(1000)));
      endcase
      goal = items_sent + 250;
      calm = (ph == 2);
      // every phase starts with a packet that opens a frame, a keyframe if its partition index is zero
      send_packet($urandom_range(8, 1), 1, 0, 1'b0);
      while (items_sent < goal) begin
        case ($urandom_range(9))
          0:       send_noise();
          1:       send_packet($urandom_range(12), 0, 0, 1'b1);
          2:       send_packet($urandom_range(6), 1, 0, 1'b0);
          default: send_packet($urandom_range(24), 0, 0, 1'b0);
        endcase
      end
      if (ph == 1) begin
        // hold the sender until everything is out, then carry on
        go_quiet();
        wait (frame_events.size() == 0);
        send_packet($urandom_range(10), 0, 0, 1'b0);
      end
      drain();
      if (ph == 1) begin
        // a stretch with recording off; these bytes are ignored
        write_reg(CFG_RECORD_ENABLE, 24'd0);
        repeat (3) send_packet($urandom_range(10), 0, 0, 1'b0);
        drain();
        write_reg(CFG_RECORD_ENABLE, 24'd1);
      end
    end

    calm = 1'b0;
    send_packet($urandom_range(8, 1), 1, 1, 1'b0);
    drain();

    $display("covered %0d recorded bytes over header, descriptor and keyframe cases",
             items_sent);
    $display("checked %0d byte writes, %0d frame commits, %0d frame drops",
             n_writes, n_commits, n_drops);
    if (errors == 0) begin
      $display("vp8_rtp_frame_reassembler_top regression: pass");
    end else begin
      $display("vp8_rtp_frame_reassembler_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
